@@ rtl/cfrd_pkg.sv @@
package cfrd_pkg;

   // fixed field widths
   localparam int unsigned ByteW   = 8;
   localparam int unsigned CountW  = 8;
   localparam int unsigned RepW    = 4;
   localparam int unsigned PlaneW  = 12;
   localparam int unsigned PixelsPerLine = 12;
   localparam int unsigned LineW   = 2 * PixelsPerLine;

   typedef logic [ByteW-1:0]  byte_type;
   typedef logic [CountW-1:0] count_type;
   typedef logic [RepW-1:0]   rep_type;
   typedef logic [PlaneW-1:0] plane_type;
   typedef logic [LineW-1:0]  line_type;

   // interleave the two bit planes, leftmost pixel in the top bits
   function automatic line_type merge_planes(input plane_type p0, input plane_type p1);
      line_type w;
      w = '0;
      for (int i = 0; i < PixelsPerLine; i++) begin
         w[2*i]   = p0[i];
         w[2*i+1] = p1[i];
      end
      return w;
   endfunction

endpackage

@@ rtl/cfrd_if.sv @@
// font byte channel
interface cfrd_req_if;
   logic                valid;
   logic                ready;
   cfrd_pkg::byte_type  font_byte;
   logic                glyph_raw;
   modport source (output valid, font_byte, glyph_raw, input ready);
   modport sink   (input valid, font_byte, glyph_raw, output ready);
endinterface

// decoded line channel
interface cfrd_rsp_if;
   logic                valid;
   logic                ready;
   cfrd_pkg::line_type  line_pixels;
   logic                last_of_run;
   logic                glyph_end;
   logic                all_done;
   modport source (output valid, line_pixels, last_of_run, glyph_end, all_done, input ready);
   modport sink   (input valid, line_pixels, last_of_run, glyph_end, all_done, output ready);
endinterface

// glyph count register write channel
interface cfrd_csr_if;
   logic                valid;
   logic                ready;
   cfrd_pkg::count_type glyph_count;
   modport source (output valid, glyph_count, input ready);
   modport sink   (input valid, glyph_count, output ready);
endinterface

@@ rtl/color_font_rle_decoder_2bpp.sv @@
// Channel   Direction  Word carried
// req_if    in         font_byte[7:0], glyph_raw
// rsp_if    out        line_pixels[23:0], last_of_run, glyph_end, all_done
// csr_if    in         glyph_count[7:0], always ready
//
// A font byte is taken when req_if.valid and req_if.ready are both high. A byte that completes a record then holds
// req_if.ready low while its k lines (0..15) drain, one per cycle on rsp_if unless rsp_if stalls; the line
// down-counter run_left_ff counts them out.
// Reset is synchronous, active high, and clears the decoder to "no glyph open".
// A stalled rsp_if holds the current line word and the input stays blocked.
module color_font_rle_decoder_2bpp #(
   parameter int unsigned LINES_PER_GLYPH = 18
) (
   input  logic              clock,
   input  logic              reset,
   cfrd_req_if.sink          req_if,
   cfrd_rsp_if.source        rsp_if,
   cfrd_csr_if.sink          csr_if
);

   localparam int unsigned LinesW = $clog2(LINES_PER_GLYPH + 1);
   localparam int unsigned CmpW   = (LinesW > cfrd_pkg::RepW) ? LinesW : cfrd_pkg::RepW;
   localparam logic [LinesW-1:0] LinesFull = LinesW'(LINES_PER_GLYPH);

   // byte position within a record or raw line
   localparam logic [1:0] PhWordHi   = 2'd0;
   localparam logic [1:0] PhWordLo   = 2'd1;
   localparam logic [1:0] PhPeek     = 2'd2;
   localparam logic [1:0] PhPlaneLo  = 2'd3;

   // state
   logic [1:0]           phase_ff, phase_in;
   logic [15:0]          first_word_ff, first_word_in;
   cfrd_pkg::byte_type   second_high_ff, second_high_in;
   logic                 held_ff, held_in;
   logic [LinesW-1:0]    lines_left_ff, lines_left_in;
   logic                 raw_ff, raw_in;
   logic [15:0]          raw_buf_ff, raw_buf_in;
   cfrd_pkg::count_type  glyphs_left_ff, glyphs_left_in;
   cfrd_pkg::count_type  glyph_count_ff;

   // line emitter
   cfrd_pkg::rep_type    run_left_ff, run_left_in;
   cfrd_pkg::line_type   word_ff, word_in;
   logic                 end_ff, end_in;
   logic                 done_ff, done_in;

   logic                 req_fire, rsp_fire;
   cfrd_pkg::byte_type   b;

   // shared run unit operands and results
   logic                 do_run;
   cfrd_pkg::rep_type    reps;
   cfrd_pkg::plane_type  p0, p1;
   cfrd_pkg::rep_type    k;
   logic [LinesW-1:0]    lines_after;
   logic                 run_ends;
   cfrd_pkg::count_type  glyphs_after;

   logic                 start_glyph;
   cfrd_pkg::count_type  glyph_src;

   assign b        = req_if.font_byte;
   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;

   // handshakes
   assign req_if.ready       = (run_left_ff == '0);
   assign rsp_if.valid       = (run_left_ff != '0);
   assign rsp_if.line_pixels = word_ff;
   assign rsp_if.last_of_run = (run_left_ff == cfrd_pkg::RepW'(1));
   assign rsp_if.glyph_end   = rsp_if.last_of_run && end_ff;
   assign rsp_if.all_done    = rsp_if.last_of_run && done_ff;
   assign csr_if.ready       = 1'b1;

   // operand select for the run unit
   always_comb begin
      do_run = 1'b0;
      reps   = first_word_ff[15:12];
      p0     = first_word_ff[11:0];
      p1     = first_word_ff[11:0];
      if (held_ff && raw_ff) begin
         if (phase_ff == PhPeek) begin
            do_run = 1'b1;
            reps   = cfrd_pkg::RepW'(1);
            p0     = {raw_buf_ff[11:8], raw_buf_ff[7:0]};
            p1     = {raw_buf_ff[15:12], b};
         end
      end else if (held_ff) begin
         if (phase_ff == PhPeek && b[7:4] != 4'h0) begin
            do_run = 1'b1;
         end else if (phase_ff == PhPlaneLo) begin
            do_run = 1'b1;
            p1     = {second_high_ff[3:0], b};
         end
      end
   end

   // run unit: clip repeat to lines left, detect glyph end
   always_comb begin
      if (CmpW'(reps) < CmpW'(lines_left_ff)) begin
         k = reps;
      end else begin
         k = cfrd_pkg::RepW'(lines_left_ff);
      end
      lines_after  = lines_left_ff - LinesW'(k);
      run_ends     = do_run && (k != '0) && (lines_after == '0);
      glyphs_after = glyphs_left_ff - cfrd_pkg::CountW'(1);
   end

   // byte decode
   always_comb begin
      phase_in       = phase_ff;
      first_word_in  = first_word_ff;
      second_high_in = second_high_ff;
      held_in        = held_ff;
      lines_left_in  = lines_left_ff;
      raw_in         = raw_ff;
      raw_buf_in     = raw_buf_ff;
      glyphs_left_in = glyphs_left_ff;
      start_glyph    = 1'b0;
      glyph_src      = glyphs_left_ff;

      if (req_fire) begin
         if (!held_ff) begin
            start_glyph = 1'b1;
         end else if (raw_ff) begin
            case (phase_ff)
               PhWordLo: begin
                  raw_buf_in = {raw_buf_ff[15:8], b};
                  phase_in   = PhPeek;
               end
               PhPeek: begin
                  phase_in = PhWordHi;
               end
               default: begin
                  raw_buf_in = {b, 8'h00};
                  phase_in   = PhWordLo;
               end
            endcase
         end else begin
            case (phase_ff)
               PhWordHi: begin
                  first_word_in = {b, 8'h00};
                  phase_in      = PhWordLo;
               end
               PhWordLo: begin
                  first_word_in = {first_word_ff[15:8], b};
                  phase_in      = PhPeek;
               end
               PhPeek: begin
                  if (b[7:4] != 4'h0) begin
                     // peeked byte opens the next record or glyph
                     if (run_ends) begin
                        start_glyph = 1'b1;
                        glyph_src   = glyphs_after;
                     end else begin
                        first_word_in = {b, 8'h00};
                        phase_in      = PhWordLo;
                     end
                  end else begin
                     second_high_in = b;
                     phase_in       = PhPlaneLo;
                  end
               end
               default: begin
                  phase_in = PhWordHi;
               end
            endcase
         end

         // commit the run
         if (do_run) begin
            lines_left_in = lines_after;
            if (run_ends) begin
               glyphs_left_in = glyphs_after;
               held_in        = 1'b0;
               phase_in       = PhWordHi;
            end
         end

         // open a new glyph
         if (start_glyph) begin
            if (glyph_src == '0) begin
               glyphs_left_in = (glyph_count_ff != '0) ? glyph_count_ff
                                                       : cfrd_pkg::CountW'(1);
            end else begin
               glyphs_left_in = glyph_src;
            end
            raw_in        = req_if.glyph_raw;
            lines_left_in = LinesFull;
            held_in       = 1'b1;
            phase_in      = PhWordLo;
            if (req_if.glyph_raw) begin
               raw_buf_in = {b, 8'h00};
            end else begin
               first_word_in = {b, 8'h00};
            end
         end
      end
   end

   // line emitter load and drain
   always_comb begin
      run_left_in = run_left_ff;
      word_in     = word_ff;
      end_in      = end_ff;
      done_in     = done_ff;
      if (req_fire && do_run && k != '0) begin
         run_left_in = k;
         word_in     = cfrd_pkg::merge_planes(p0, p1);
         end_in      = run_ends;
         done_in     = run_ends && (glyphs_after == '0);
      end else if (rsp_fire) begin
         run_left_in = run_left_ff - cfrd_pkg::RepW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PhWordHi;
         held_ff        <= 1'b0;
         lines_left_ff  <= LinesFull;
         raw_ff         <= 1'b0;
         glyphs_left_ff <= '0;
         glyph_count_ff <= cfrd_pkg::CountW'(1);
         run_left_ff    <= '0;
      end else begin
         phase_ff       <= phase_in;
         held_ff        <= held_in;
         lines_left_ff  <= lines_left_in;
         raw_ff         <= raw_in;
         glyphs_left_ff <= glyphs_left_in;
         run_left_ff    <= run_left_in;
         if (csr_if.valid && csr_if.ready) begin
            glyph_count_ff <= csr_if.glyph_count;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      first_word_ff  <= first_word_in;
      second_high_ff <= second_high_in;
      raw_buf_ff     <= raw_buf_in;
      word_ff        <= word_in;
      end_ff         <= end_in;
      done_ff        <= done_in;
   end

`ifndef SYNTH
   // an open glyph always still needs lines
   a_open_needs_lines: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> (lines_left_ff != '0))
      else $error("open glyph with no lines left");

   // an open glyph always belongs to a running batch
   a_open_in_batch: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> (glyphs_left_ff != '0))
      else $error("open glyph outside a batch");

   // a taken line that is not the last of its run is followed by another
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_if.last_of_run) |=> rsp_if.valid)
      else $error("run ended early");

   // batch completion only ever coincides with a glyph end
   a_done_ends_glyph: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.all_done) |-> rsp_if.glyph_end)
      else $error("all_done without glyph_end");
`endif

endmodule

@@ verif/color_font_rle_decoder_2bpp_tb.sv @@
module color_font_rle_decoder_2bpp_tb;

   localparam int unsigned GlyphLines  = 18;
   localparam int unsigned HoldCycles  = 400;
   localparam int unsigned DrainCycles = 24;
   localparam int unsigned CycleLimit  = 400000;

   // position inside a record (compressed) or inside a line (raw)
   typedef enum logic [1:0] {PH_HIGH, PH_LOW, PH_NEXT, PH_PLANE1} byte_phase_type;

   typedef struct packed {
      cfrd_pkg::byte_type font_byte;
      logic               glyph_raw;
   } font_word_type;

   typedef struct packed {
      cfrd_pkg::line_type line_pixels;
      logic               last_of_run;
      logic               glyph_end;
      logic               all_done;
   } line_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cfrd_req_if req_if();
   cfrd_rsp_if rsp_if();
   cfrd_csr_if csr_if();

   // locally held drive values, known from time zero
   logic                req_valid = 1'b0;
   cfrd_pkg::byte_type  req_byte  = '0;
   logic                req_raw   = 1'b0;
   logic                rsp_ready = 1'b0;
   logic                csr_valid = 1'b0;
   cfrd_pkg::count_type csr_count = 8'd1;

   assign req_if.valid       = req_valid;
   assign req_if.font_byte   = req_byte;
   assign req_if.glyph_raw   = req_raw;
   assign rsp_if.ready       = rsp_ready;
   assign csr_if.valid       = csr_valid;
   assign csr_if.glyph_count = csr_count;

   color_font_rle_decoder_2bpp #(.LINES_PER_GLYPH(GlyphLines)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   initial forever #5 clock = ~clock;

   font_word_type  font_words[$];
   line_word_type  lines_due[$];

   int unsigned send_idle_pct = 35;
   int unsigned recv_idle_pct = 84;
   int unsigned hold_asked    = 0;
   int unsigned hold_served   = 0;
   int unsigned hold_left     = 0;
   int unsigned cycle_count   = 0;
   int unsigned errors        = 0;
   int unsigned bytes_queued  = 0;
   int unsigned bytes_taken   = 0;
   int unsigned lines_checked = 0;
   int unsigned glyphs_seen   = 0;
   int unsigned raw_glyphs    = 0;

   // decoder state as the testbench sees it
   cfrd_pkg::count_type cfg_glyph_count;
   byte_phase_type      rec_phase;
   logic [15:0]         rec_word;
   cfrd_pkg::byte_type  plane1_high;
   logic                glyph_open;
   logic [4:0]          lines_to_go;
   logic                open_is_raw;
   logic [15:0]         raw_pair;
   cfrd_pkg::count_type batch_left;

   function automatic logic coin();
      return ($urandom_range(1) == 1);
   endfunction

   // push the line words of one run, clipped to the lines the glyph still needs
   task automatic emit_lines(input cfrd_pkg::plane_type p0, input cfrd_pkg::plane_type p1,
                             input cfrd_pkg::rep_type reps);
      int unsigned        k;
      logic               closes;
      cfrd_pkg::line_type w;
      line_word_type      e;
      k = (reps < lines_to_go) ? reps : lines_to_go;
      w = '0;
      for (int b = cfrd_pkg::PlaneW - 1; b >= 0; b--)
         w = {w[cfrd_pkg::LineW-3:0], p1[b], p0[b]};
      lines_to_go = lines_to_go - 5'(k);
      closes = (k > 0) && (lines_to_go == 0);
      if (closes) begin
         batch_left  = batch_left - 8'd1;
         glyph_open  = 1'b0;
         rec_phase   = PH_HIGH;
      end
      for (int unsigned i = 0; i < k; i++) begin
         e.line_pixels = w;
         e.last_of_run = (i == k - 1);
         e.glyph_end   = closes && (i == k - 1);
         e.all_done    = closes && (i == k - 1) && (batch_left == 0);
         lines_due.push_back(e);
      end
   endtask

   task automatic open_glyph(input cfrd_pkg::byte_type b, input logic raw);
      if (batch_left == 0) batch_left = (cfg_glyph_count != 0) ? cfg_glyph_count : 8'd1;
      open_is_raw = raw;
      lines_to_go = 5'(GlyphLines);
      glyph_open  = 1'b1;
      if (raw) raw_pair = {b, 8'h00};
      else rec_word = {b, 8'h00};
      rec_phase = PH_LOW;
      if (raw) raw_glyphs++;
   endtask

   // expected line words for one accepted font word
   task automatic decode_font_byte(input cfrd_pkg::byte_type b, input logic raw);
      if (!glyph_open) begin
         open_glyph(b, raw);
      end else if (open_is_raw) begin
         case (rec_phase)
            PH_LOW: begin
               raw_pair[7:0] = b;
               rec_phase = PH_NEXT;
            end
            PH_NEXT: begin
               rec_phase = PH_HIGH;
               emit_lines(raw_pair[11:0], {raw_pair[15:12], b}, 4'd1);
            end
            default: begin
               raw_pair  = {b, 8'h00};
               rec_phase = PH_LOW;
            end
         endcase
      end else begin
         case (rec_phase)
            PH_HIGH: begin
               rec_word  = {b, 8'h00};
               rec_phase = PH_LOW;
            end
            PH_LOW: begin
               rec_word[7:0] = b;
               rec_phase = PH_NEXT;
            end
            PH_NEXT: begin
               if (b[7:4] != 4'h0) begin
                  // single plane: this byte already belongs to the next record
                  emit_lines(rec_word[11:0], rec_word[11:0], rec_word[15:12]);
                  if (!glyph_open) open_glyph(b, raw);
                  else begin
                     rec_word  = {b, 8'h00};
                     rec_phase = PH_LOW;
                  end
               end else begin
                  plane1_high = b;
                  rec_phase   = PH_PLANE1;
               end
            end
            default: begin
               rec_phase = PH_HIGH;
               emit_lines(rec_word[11:0], {plane1_high[3:0], b}, rec_word[15:12]);
            end
         endcase
      end
   endtask

   // driver: next font word whenever the channel is free
   always @(posedge clock) begin : feed
      font_word_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_if.ready) begin
         if (font_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = font_words.pop_front();
            req_valid <= 1'b1;
            req_byte  <= item.font_byte;
            req_raw   <= item.glyph_raw;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: track config and font words, check line words, drive ready
   always @(posedge clock) begin : watch
      line_word_type want;
      if (reset) begin
         rsp_ready       <= 1'b0;
         cfg_glyph_count = 8'd1;
         rec_phase       = PH_HIGH;
         rec_word        = '0;
         plane1_high     = '0;
         glyph_open      = 1'b0;
         lines_to_go     = 5'(GlyphLines);
         open_is_raw     = 1'b0;
         raw_pair        = '0;
         batch_left      = '0;
      end else begin
         if (csr_valid && csr_if.ready) cfg_glyph_count = csr_count;
         if (req_if.valid && req_if.ready) begin
            decode_font_byte(req_if.font_byte, req_if.glyph_raw);
            bytes_taken++;
         end
         if (rsp_if.valid && rsp_ready) begin
            if (lines_due.size() == 0) begin
               $error("unexpected line word %06h", rsp_if.line_pixels);
               errors++;
            end else begin
               want = lines_due.pop_front();
               lines_checked++;
               if (rsp_if.glyph_end === 1'b1) glyphs_seen++;
               if (rsp_if.line_pixels !== want.line_pixels) begin
                  $error("line_pixels: expected %06h, got %06h",
                         want.line_pixels, rsp_if.line_pixels);
                  errors++;
               end
               if (rsp_if.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, got %0b",
                         want.last_of_run, rsp_if.last_of_run);
                  errors++;
               end
               if (rsp_if.glyph_end !== want.glyph_end) begin
                  $error("glyph_end: expected %0b, got %0b", want.glyph_end, rsp_if.glyph_end);
                  errors++;
               end
               if (rsp_if.all_done !== want.all_done) begin
                  $error("all_done: expected %0b, got %0b", want.all_done, rsp_if.all_done);
                  errors++;
               end
            end
         end
         // long hold-off on request, else random back-pressure
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HoldCycles;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("color_font_rle_decoder_2bpp: mismatch");
         $finish;
      end
   end

   task automatic queue_byte(input cfrd_pkg::byte_type b, input logic raw);
      font_words.push_back('{font_byte: b, glyph_raw: raw});
      bytes_queued++;
   endtask

   // one well-formed glyph; need_high says the first byte must double as a peek
   task automatic queue_glyph(inout bit need_high);
      int unsigned         left, rep, cap, pick;
      cfrd_pkg::plane_type p0, p1;
      cfrd_pkg::byte_type  b0;
      bit                  two_planes, opening;
      if ($urandom_range(99) < 30) begin
         for (int unsigned n = 0; n < 3 * GlyphLines; n++) begin
            b0 = 8'($urandom);
            if (n == 0 && need_high && b0[7:4] == 4'h0) b0[7:4] = 4'($urandom_range(15, 1));
            queue_byte(b0, (n == 0) ? 1'b1 : coin());
         end
         need_high = 1'b0;
      end else begin
         left    = GlyphLines;
         opening = 1'b1;
         while (left != 0) begin
            cap  = (left < 15) ? left : 15;
            pick = $urandom_range(99);
            if (pick < 8 && !need_high) rep = 0;
            else if (pick < 22) rep = $urandom_range(15, cap);
            else rep = $urandom_range(1, (cap < 5) ? cap : 5);
            p0 = 12'($urandom);
            p1 = 12'($urandom);
            two_planes = coin();
            queue_byte({4'(rep), p0[11:8]}, opening ? 1'b0 : coin());
            queue_byte(p0[7:0], coin());
            if (two_planes) begin
               queue_byte({4'h0, p1[11:8]}, coin());
               queue_byte(p1[7:0], coin());
            end
            left      = (rep >= left) ? 0 : left - rep;
            need_high = !two_planes;
            opening   = 1'b0;
         end
      end
   endtask

   // sender pause: everything taken and every line word back
   task automatic settle();
      while (font_words.size() != 0 || req_valid || lines_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic run_phase(input cfrd_pkg::count_type count, input int unsigned send_pct,
                            input int unsigned recv_pct, input int unsigned nbytes,
                            input int unsigned noise, input bit hold);
      bit                 need_high;
      int unsigned        first;
      cfrd_pkg::byte_type b;
      settle();
      // finish any glyph still open so the new stream starts on a boundary
      while (glyph_open) begin
         if (open_is_raw) b = 8'($urandom);
         else begin
            case (rec_phase)
               PH_HIGH: b = {4'hF, 4'($urandom)};
               PH_NEXT: b = {4'h0, 4'($urandom)};
               default: b = 8'($urandom);
            endcase
         end
         queue_byte(b, coin());
         settle();
      end
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_count <= count;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_valid <= 1'b0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (hold) hold_asked++;
      need_high = 1'b0;
      first = bytes_queued;
      while (bytes_queued - first < nbytes) queue_glyph(need_high);
      repeat (noise) queue_byte(8'($urandom), coin());
   endtask

   initial begin
      logic [8:0]          opening [20];
      cfrd_pkg::count_type last_count;
      // bit 8 is glyph_raw; two-plane run, zero repeat, single-plane runs,
      // overrun ending at a peeked byte that opens the next glyph
      opening = '{9'h0F0, 9'h000, 9'h00F, 9'h0FF, 9'h10A, 9'h0BC, 9'h01F, 9'h0FF,
                  9'h000, 9'h000, 9'h0F1, 9'h023, 9'h080, 9'h000, 9'h00F, 9'h0FF,
                  9'h0A5, 9'h05A, 9'h00A, 9'h0A5};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (opening[i]) queue_byte(opening[i][7:0], opening[i][8]);

      last_count = 8'($urandom_range(255, 1));
      run_phase(8'd2,   35, 84, 16, 0,  1'b1);
      run_phase(8'd0,   35, 84, 14, 0,  1'b0);
      run_phase(8'd255, 84, 35, 16, 0,  1'b0);
      run_phase(8'd1,   84, 35, 14, 0,  1'b0);
      run_phase(8'd3,   0,  0,  16, 12, 1'b1);
      run_phase(last_count, 0, 0, 12, 0, 1'b0);
      settle();

      $display("decoded %0d font bytes into %0d line words, %0d glyphs closed, %0d raw opened",
               bytes_taken, lines_checked, glyphs_seen, raw_glyphs);
      $display("glyph counts 1, 2, 0, 255, 1, 3, %0d; back-pressure both ways, two hold-offs",
               last_count);
      if (errors == 0) $display("color_font_rle_decoder_2bpp: match");
      else $display("color_font_rle_decoder_2bpp: mismatch");
      $finish;
   end

endmodule
